[rtl/core/video_unit_register_port_top_macros.svh]
// Assertion helpers shared by the RTL; clocked on aclk, off while aresetn is low.
`ifndef VIDEO_UNIT_REGISTER_PORT_TOP_MACROS_SVH
`define VIDEO_UNIT_REGISTER_PORT_TOP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define VURP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define VURP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/vurp_pkg.sv]
package vurp_pkg;

    typedef logic [1:0]  opcode_t;
    typedef logic [2:0]  reg_idx_t;
    typedef logic [7:0]  byte_t;
    typedef logic [14:0] vaddr_t;
    typedef logic [8:0]  count_t;

    // opcodes
    localparam opcode_t OP_READ  = 2'd0;
    localparam opcode_t OP_WRITE = 2'd1;
    localparam opcode_t OP_TICK  = 2'd2;

    // register indexes
    localparam reg_idx_t REG_CTRL     = 3'd0;
    localparam reg_idx_t REG_MASK     = 3'd1;
    localparam reg_idx_t REG_STATUS   = 3'd2;
    localparam reg_idx_t REG_OAM_ADDR = 3'd3;
    localparam reg_idx_t REG_OAM_DATA = 3'd4;
    localparam reg_idx_t REG_SCROLL   = 3'd5;
    localparam reg_idx_t REG_ADDR     = 3'd6;
    localparam reg_idx_t REG_DATA     = 3'd7;

    // memory sizes
    localparam int NAME_BYTES    = 2048;
    localparam int PATTERN_BYTES = 8192;
    localparam int SPRITE_BYTES  = 256;
    localparam int PALETTE_BYTES = 32;
    localparam int NAME_AW       = $clog2(NAME_BYTES);
    localparam int PATTERN_AW    = $clog2(PATTERN_BYTES);
    localparam int SPRITE_AW     = $clog2(SPRITE_BYTES);
    localparam int PALETTE_AW    = $clog2(PALETTE_BYTES);

    // raster timing
    localparam int     DOTS_PER_LINE   = 341;
    localparam int     LINES_PER_FRAME = 262;
    localparam count_t LAST_DOT        = count_t'(DOTS_PER_LINE - 1);
    localparam count_t LAST_LINE       = count_t'(LINES_PER_FRAME - 1);
    localparam count_t VBLANK_SET_LINE = 9'd241;
    localparam count_t VBLANK_CLR_LINE = 9'd261;
    localparam count_t VBLANK_DOT      = 9'd1;

    // temp address keep masks
    localparam vaddr_t T_KEEP_CTRL    = 15'h73ff;
    localparam vaddr_t T_KEEP_SCROLL0 = 15'h7fe0;
    localparam vaddr_t T_KEEP_SCROLL1 = 15'h0c1f;
    localparam vaddr_t T_KEEP_ADDR0   = 15'h00ff;
    localparam vaddr_t T_KEEP_ADDR1   = 15'h7f00;

    // data port address map (14 bits)
    localparam logic [13:0] NT_MIRROR_LO = 14'h3000;
    localparam logic [13:0] NT_MIRROR_HI = 14'h3eff;
    localparam logic [13:0] NT_MIRROR_MASK = 14'h2eff;
    localparam logic [5:0]  PAL_PAGE     = 6'h3f;

    localparam vaddr_t INC_ACROSS = 15'd1;
    localparam vaddr_t INC_DOWN   = 15'd32;

endpackage

[rtl/core/video_unit_register_port_top.sv]
// Channel | Handshake         | Payload
// --------+-------------------+---------------------------------------------
// input   | s_valid s_ready   | s_opcode s_reg_index s_write_data
// result  | m_valid m_ready   | m_read_data m_nmi_active m_in_vblank
// config  | cfg_wr_en         | cfg_wr_data (mirroring mode)
//
// One beat per cycle while results are taken: an accepted beat is staged, executes
// from the stage register, and its result is registered into m_valid and the payload.
// Memory reads are registered; sprite and palette bytes come from a read-ahead.
// aresetn (synchronous) clears control state; memories are not cleared.
// m_ready low holds the result and stalls execution, then input acceptance.
`include "video_unit_register_port_top_macros.svh"

module video_unit_register_port_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  vurp_pkg::opcode_t  s_opcode,
    input  vurp_pkg::reg_idx_t s_reg_index,
    input  vurp_pkg::byte_t    s_write_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vurp_pkg::byte_t    m_read_data,
    output logic               m_nmi_active,
    output logic               m_in_vblank
);
    import vurp_pkg::*;

    logic     mirror_reg;
    logic     stage_valid_reg;
    opcode_t  stage_op_reg;
    reg_idx_t stage_idx_reg;
    byte_t    stage_data_reg;

    vaddr_t vram_addr_reg, vram_addr_next;
    vaddr_t temp_addr_reg, temp_addr_next;
    logic   toggle_reg, toggle_next;
    byte_t  ctrl_reg, ctrl_next;
    byte_t  sprite_addr_reg, sprite_addr_next;
    byte_t  open_bus_reg, open_bus_next;
    logic   vblank_reg, vblank_next;
    count_t dot_reg, dot_next;
    count_t line_reg, line_next;

    logic   buf_loaded_reg, buf_loaded_next;
    logic   buf_src_reg;
    byte_t  buf_value;

    byte_t  sprite_mem [SPRITE_BYTES];
    byte_t  name_mem [NAME_BYTES];
    byte_t  pattern_mem [PATTERN_BYTES];
    byte_t  palette_mem [PALETTE_BYTES];
    byte_t  sprite_q_reg;
    byte_t  name_q_reg;
    byte_t  pattern_q_reg;
    byte_t  palette_q_reg;
    byte_t  sprite_rd_addr;

    logic   sprite_we, name_we, pattern_we, palette_we;
    logic   port_rd;

    logic                  exec_fire;
    logic                  status_rd_fire;
    logic [13:0]           raw_addr;
    logic [13:0]           port_addr;
    logic                  port_pal;
    logic                  port_name;
    logic [1:0]            nt_table;
    logic                  nt_phys;
    logic [NAME_AW-1:0]    name_idx;
    logic [PATTERN_AW-1:0] pattern_idx;
    logic [PALETTE_AW-1:0] palette_idx;
    logic [PALETTE_AW-1:0] palette_rd_idx;
    vaddr_t                vram_step;

    logic  m_valid_reg;
    byte_t m_read_data_reg;
    logic  m_nmi_reg;
    logic  m_vblank_reg;

    assign exec_fire = stage_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !stage_valid_reg || exec_fire;

    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_read_data_reg;
    assign m_nmi_active = m_nmi_reg;
    assign m_in_vblank  = m_vblank_reg;

    // data port address decode
    assign raw_addr  = vram_addr_reg[13:0];
    assign port_addr = (raw_addr >= NT_MIRROR_LO && raw_addr <= NT_MIRROR_HI)
                       ? (raw_addr & NT_MIRROR_MASK) : raw_addr;
    assign port_pal  = (port_addr[13:8] == PAL_PAGE);
    assign port_name = port_addr[13];
    assign nt_table  = port_addr[11:10];
    assign nt_phys   = mirror_reg ? nt_table[0] : nt_table[1];
    assign name_idx  = NAME_AW'({nt_phys, port_addr[9:0]});
    assign pattern_idx = port_addr[PATTERN_AW-1:0];
    assign palette_idx = port_addr[PALETTE_AW-1:0];
    assign vram_step = ctrl_reg[2] ? INC_DOWN : INC_ACROSS;

    // buffered read value: zero until the first buffered load
    assign buf_value = !buf_loaded_reg ? '0 : (buf_src_reg ? name_q_reg : pattern_q_reg);

    assign status_rd_fire = exec_fire && (stage_op_reg == OP_READ)
                            && (stage_idx_reg == REG_STATUS);

    always_comb begin
        vram_addr_next   = vram_addr_reg;
        temp_addr_next   = temp_addr_reg;
        toggle_next      = toggle_reg;
        ctrl_next        = ctrl_reg;
        sprite_addr_next = sprite_addr_reg;
        open_bus_next    = open_bus_reg;
        vblank_next      = vblank_reg;
        dot_next         = dot_reg;
        line_next        = line_reg;
        buf_loaded_next  = buf_loaded_reg;
        sprite_we        = 1'b0;
        name_we          = 1'b0;
        pattern_we       = 1'b0;
        palette_we       = 1'b0;
        port_rd          = 1'b0;
        if (exec_fire) begin
            case (stage_op_reg)
                OP_READ: begin
                    unique case (stage_idx_reg)
                        REG_STATUS: begin
                            open_bus_next = {vblank_reg, 2'b00, open_bus_reg[4:0]};
                            toggle_next   = 1'b0;
                            vblank_next   = 1'b0;
                        end
                        REG_OAM_DATA: begin
                            open_bus_next = sprite_q_reg;
                        end
                        REG_DATA: begin
                            if (port_pal) begin
                                open_bus_next = palette_q_reg;
                            end else begin
                                open_bus_next   = buf_value;
                                port_rd         = 1'b1;
                                buf_loaded_next = 1'b1;
                            end
                            vram_addr_next = vram_addr_reg + vram_step;
                        end
                        default: ;
                    endcase
                end
                OP_WRITE: begin
                    open_bus_next = stage_data_reg;
                    unique case (stage_idx_reg)
                        REG_CTRL: begin
                            ctrl_next      = stage_data_reg;
                            temp_addr_next = (temp_addr_reg & T_KEEP_CTRL)
                                             | {3'b000, stage_data_reg[1:0], 10'b0};
                        end
                        REG_OAM_ADDR: begin
                            sprite_addr_next = stage_data_reg;
                        end
                        REG_OAM_DATA: begin
                            sprite_we        = 1'b1;
                            sprite_addr_next = sprite_addr_reg + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (!toggle_reg) begin
                                temp_addr_next = (temp_addr_reg & T_KEEP_SCROLL0)
                                                 | {10'b0, stage_data_reg[7:3]};
                                toggle_next    = 1'b1;
                            end else begin
                                temp_addr_next = (temp_addr_reg & T_KEEP_SCROLL1)
                                                 | {stage_data_reg[2:0], 2'b00,
                                                    stage_data_reg[7:3], 5'b0};
                                toggle_next    = 1'b0;
                            end
                        end
                        REG_ADDR: begin
                            if (!toggle_reg) begin
                                temp_addr_next = (temp_addr_reg & T_KEEP_ADDR0)
                                                 | {1'b0, stage_data_reg[5:0], 8'b0};
                                toggle_next    = 1'b1;
                            end else begin
                                temp_addr_next = (temp_addr_reg & T_KEEP_ADDR1)
                                                 | {7'b0, stage_data_reg};
                                vram_addr_next = temp_addr_next;
                                toggle_next    = 1'b0;
                            end
                        end
                        REG_DATA: begin
                            if (port_pal) begin
                                palette_we = 1'b1;
                            end else if (port_name) begin
                                name_we = 1'b1;
                            end else begin
                                pattern_we = 1'b1;
                            end
                            vram_addr_next = vram_addr_reg + vram_step;
                        end
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    if (dot_reg == VBLANK_DOT && line_reg == VBLANK_SET_LINE) begin
                        vblank_next = 1'b1;
                    end else if (dot_reg == VBLANK_DOT && line_reg == VBLANK_CLR_LINE) begin
                        vblank_next = 1'b0;
                    end
                    if (dot_reg >= LAST_DOT) begin
                        dot_next  = '0;
                        line_next = (line_reg >= LAST_LINE) ? '0 : line_reg + 9'd1;
                    end else begin
                        dot_next = dot_reg + 9'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg      <= 1'b0;
            stage_valid_reg <= 1'b0;
            vram_addr_reg   <= '0;
            temp_addr_reg   <= '0;
            toggle_reg      <= 1'b0;
            ctrl_reg        <= '0;
            sprite_addr_reg <= '0;
            open_bus_reg    <= '0;
            vblank_reg      <= 1'b0;
            dot_reg         <= '0;
            line_reg        <= '0;
            buf_loaded_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mirror_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                stage_valid_reg <= s_valid;
            end
            vram_addr_reg   <= vram_addr_next;
            temp_addr_reg   <= temp_addr_next;
            toggle_reg      <= toggle_next;
            ctrl_reg        <= ctrl_next;
            sprite_addr_reg <= sprite_addr_next;
            open_bus_reg    <= open_bus_next;
            vblank_reg      <= vblank_next;
            dot_reg         <= dot_next;
            line_reg        <= line_next;
            buf_loaded_reg  <= buf_loaded_next;
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_op_reg   <= s_opcode;
            stage_idx_reg  <= s_reg_index;
            stage_data_reg <= s_write_data;
        end
        if (exec_fire) begin
            m_read_data_reg <= open_bus_next;
            m_nmi_reg       <= vblank_next && ctrl_next[7];
            m_vblank_reg    <= vblank_next;
        end
        if (port_rd) begin
            buf_src_reg <= port_name;
        end
    end

    // sprite memory: read ahead at the address the next beat will see
    assign sprite_rd_addr = aresetn ? sprite_addr_next : '0;

    always_ff @(posedge aclk) begin
        if (sprite_we) begin
            sprite_mem[sprite_addr_reg[SPRITE_AW-1:0]] <= stage_data_reg;
        end
        sprite_q_reg <= sprite_mem[sprite_rd_addr[SPRITE_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (name_we) begin
            name_mem[name_idx] <= stage_data_reg;
        end
        if (port_rd && port_name) begin
            name_q_reg <= name_mem[name_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (pattern_we) begin
            pattern_mem[pattern_idx] <= stage_data_reg;
        end
        if (port_rd && !port_name) begin
            pattern_q_reg <= pattern_mem[pattern_idx];
        end
    end

    // palette: read ahead at the next port address; low address bits never mirror
    assign palette_rd_idx = vram_addr_next[PALETTE_AW-1:0];

    always_ff @(posedge aclk) begin
        if (palette_we) begin
            palette_mem[palette_idx] <= stage_data_reg;
        end
        // forward a write that lands on the entry being read ahead
        if (palette_we && palette_idx == palette_rd_idx) begin
            palette_q_reg <= stage_data_reg;
        end else begin
            palette_q_reg <= palette_mem[palette_rd_idx];
        end
    end

    `VURP_ASSERT_NOW(a_dot_range, 1'b1, dot_reg <= LAST_DOT, "dot counter out of range")
    `VURP_ASSERT_NOW(a_line_range, 1'b1, line_reg <= LAST_LINE, "line counter out of range")
    `VURP_ASSERT_NEXT(a_status_clr, status_rd_fire, !vblank_reg && !toggle_reg, "flags still set")
    `VURP_ASSERT_NEXT(a_result_reg, exec_fire, m_valid_reg, "executed beat lost")
    `VURP_ASSERT_NEXT(a_vblank_out, exec_fire, m_vblank_reg == vblank_reg, "vblank out of step")

endmodule

[dv/tb_video_unit_register_port_top.sv]
module tb_video_unit_register_port_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vurp_pkg::*;

    localparam int          HALF_PERIOD  = 2;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          REPORT_LIMIT = 10;
    localparam opcode_t     OP_UNUSED    = 2'd3;
    localparam logic [13:0] NAME_BASE    = 14'h2000;
    localparam byte_t       CTRL_INC_32  = 8'h04;

    typedef struct packed {
        byte_t read_data;
        logic  nmi_active;
        logic  in_vblank;
    } port_result_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_pattern_t;

    // Shadow of the register port: latches, counters and memories, plus the
    // results that accepted beats are owed.
    class port_shadow;
        bit           mirror_vertical;
        bit [14:0]    vram_addr;
        bit [14:0]    temp_addr;
        bit [2:0]     fine_x;
        bit           toggle;
        bit [7:0]     ctrl;
        bit [7:0]     mask;
        bit [7:0]     oam_addr;
        bit [7:0]     open_bus;
        bit [7:0]     data_latch;
        bit           vblank;
        bit [8:0]     dot;
        bit [8:0]     line;
        bit [7:0]     oam_bytes [SPRITE_BYTES];
        bit           oam_known [SPRITE_BYTES];
        bit [7:0]     name_bytes [NAME_BYTES];
        bit           name_known [NAME_BYTES];
        bit [7:0]     pattern_bytes [PATTERN_BYTES];
        bit           pattern_known [PATTERN_BYTES];
        bit [7:0]     palette_bytes [PALETTE_BYTES];
        bit           palette_known [PALETTE_BYTES];
        port_result_t pending [$];
        int           beats_noted;
        int           results_checked;
        int           vblank_results;
        int           nmi_results;
        int           failures;

        function bit [10:0] name_slot(bit [13:0] a);
            bit [1:0] tbl;
            bit       phys;
            tbl  = a[11:10];
            phys = mirror_vertical ? tbl[0] : tbl[1];
            return {phys, a[9:0]};
        endfunction

        function bit [13:0] port_address();
            bit [13:0] a;
            a = vram_addr[13:0];
            if (a >= NT_MIRROR_LO && a <= NT_MIRROR_HI) begin
                a &= NT_MIRROR_MASK;
            end
            return a;
        endfunction

        function void step_address();
            vram_addr += ctrl[2] ? INC_DOWN : INC_ACROSS;
        endfunction

        // False when the access would read a memory entry never written.
        function bit read_allowed(reg_idx_t ri);
            bit [13:0] a;
            a = port_address();
            if (ri == REG_OAM_DATA) return oam_known[oam_addr];
            if (ri != REG_DATA) return 1'b1;
            if (a[13:8] == PAL_PAGE) return palette_known[a[4:0]];
            if (a >= NAME_BASE) return name_known[name_slot(a)];
            return pattern_known[a[12:0]];
        endfunction

        function void port_read();
            bit [13:0] a;
            a = port_address();
            if (a[13:8] == PAL_PAGE) begin
                open_bus = palette_bytes[a[4:0]];
            end else begin
                open_bus = data_latch;
                data_latch = (a >= NAME_BASE) ? name_bytes[name_slot(a)]
                                              : pattern_bytes[a[12:0]];
            end
            step_address();
        endfunction

        function void port_write(bit [7:0] wd);
            bit [13:0] a;
            a = port_address();
            if (a[13:8] == PAL_PAGE) begin
                palette_bytes[a[4:0]] = wd;
                palette_known[a[4:0]] = 1'b1;
            end else if (a >= NAME_BASE) begin
                name_bytes[name_slot(a)] = wd;
                name_known[name_slot(a)] = 1'b1;
            end else begin
                pattern_bytes[a[12:0]] = wd;
                pattern_known[a[12:0]] = 1'b1;
            end
            step_address();
        endfunction

        function void note_access(opcode_t op, reg_idx_t ri, byte_t wd);
            port_result_t r;
            beats_noted++;
            if (op == OP_READ) begin
                case (ri)
                    REG_STATUS: begin
                        open_bus = {vblank, 2'b00, open_bus[4:0]};
                        toggle   = 1'b0;
                        vblank   = 1'b0;
                    end
                    REG_OAM_DATA: open_bus = oam_bytes[oam_addr];
                    REG_DATA:     port_read();
                    default: ;
                endcase
            end else if (op == OP_WRITE) begin
                open_bus = wd;
                case (ri)
                    REG_CTRL: begin
                        ctrl = wd;
                        temp_addr = (temp_addr & T_KEEP_CTRL) | {3'b000, wd[1:0], 10'd0};
                    end
                    REG_MASK:     mask = wd;
                    REG_OAM_ADDR: oam_addr = wd;
                    REG_OAM_DATA: begin
                        oam_bytes[oam_addr] = wd;
                        oam_known[oam_addr] = 1'b1;
                        oam_addr++;
                    end
                    REG_SCROLL: begin
                        if (!toggle) begin
                            temp_addr = (temp_addr & T_KEEP_SCROLL0) | {10'd0, wd[7:3]};
                            fine_x = wd[2:0];
                            toggle = 1'b1;
                        end else begin
                            temp_addr = (temp_addr & T_KEEP_SCROLL1)
                                      | {wd[2:0], 2'b00, wd[7:3], 5'd0};
                            toggle = 1'b0;
                        end
                    end
                    REG_ADDR: begin
                        if (!toggle) begin
                            temp_addr = (temp_addr & T_KEEP_ADDR0) | {1'b0, wd[5:0], 8'd0};
                            toggle = 1'b1;
                        end else begin
                            temp_addr = (temp_addr & T_KEEP_ADDR1) | {7'd0, wd};
                            vram_addr = temp_addr;
                            toggle = 1'b0;
                        end
                    end
                    REG_DATA: port_write(wd);
                    default: ;
                endcase
            end else if (op == OP_TICK) begin
                if (dot == VBLANK_DOT && line == VBLANK_SET_LINE) begin
                    vblank = 1'b1;
                end else if (dot == VBLANK_DOT && line == VBLANK_CLR_LINE) begin
                    vblank = 1'b0;
                end
                if (dot >= LAST_DOT) begin
                    dot  = '0;
                    line = (line >= LAST_LINE) ? 9'd0 : line + 9'd1;
                end else begin
                    dot++;
                end
            end
            r.read_data  = open_bus;
            r.nmi_active = vblank & ctrl[7];
            r.in_vblank  = vblank;
            pending.push_back(r);
        endfunction

        function void check_result(byte_t rd, logic nmi, logic vb);
            port_result_t want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("unexpected result beat: read_data %h nmi %b vblank %b",
                             rd, nmi, vb);
                end
                return;
            end
            want = pending.pop_front();
            results_checked++;
            if (want.in_vblank) vblank_results++;
            if (want.nmi_active) nmi_results++;
            if (rd !== want.read_data || nmi !== want.nmi_active || vb !== want.in_vblank) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("mismatch %0d (exp/got): data %h/%h nmi %b/%b vblank %b/%b",
                             results_checked, want.read_data, rd, want.nmi_active, nmi,
                             want.in_vblank, vb);
                end
            end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     cfg_wr_en;
    logic     cfg_wr_data;
    logic     s_valid;
    logic     s_ready;
    opcode_t  s_opcode;
    reg_idx_t s_reg_index;
    byte_t    s_write_data;
    logic     m_valid;
    logic     m_ready;
    byte_t    m_read_data;
    logic     m_nmi_active;
    logic     m_in_vblank;

    port_shadow shadow = new();
    int quiet_cycles  = 0;
    int items_sent    = 0;
    int burst_left    = 0;

    video_unit_register_port_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_reg_index  (s_reg_index),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_nmi_active (m_nmi_active),
        .m_in_vblank  (m_in_vblank)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // Note input beats before checking result beats of the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                shadow.note_access(s_opcode, s_reg_index, s_write_data);
            end
            if (m_valid && m_ready) begin
                shadow.check_result(m_read_data, m_nmi_active, m_in_vblank);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("video_unit_register_port_top regression: fail");
        $finish;
    end

    // Result side: pick a new stall pattern at the end of each random-length phase.
    initial begin
        rx_pattern_t pattern;
        int          phase_left;
        int          stall_left;
        int          beat_phase;
        m_ready    = 1'b0;
        pattern    = RX_OPEN;
        phase_left = 0;
        stall_left = 0;
        beat_phase = 0;
        forever begin
            @(negedge aclk);
            if (phase_left == 0) begin
                pattern    = rx_pattern_t'($urandom_range(0, 3));
                phase_left = $urandom_range(32, 256);
            end
            phase_left--;
            beat_phase++;
            case (pattern)
                RX_OPEN:     m_ready = 1'b1;
                RX_COIN:     m_ready = ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_ready = ((beat_phase % 7) >= 2);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_ready = 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        m_ready = 1'b0;
                    end else begin
                        m_ready = 1'b1;
                    end
                end
            endcase
        end
    end

    function automatic byte_t rand_byte();
        return byte_t'($urandom);
    endfunction

    // Enter and leave at a falling edge; valid stays high on return so that
    // back-to-back beats need no second assignment in one step.
    task automatic send_beat(opcode_t op, reg_idx_t ri, byte_t wd);
        // turn a read of memory never written into a write of the same register
        if (op == OP_READ && !shadow.read_allowed(ri)) op = OP_WRITE;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_opcode     = op;
        s_reg_index  = ri;
        s_write_data = wd;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (shadow.pending.size() != 0) @(negedge aclk);
    endtask

    task automatic set_mirroring(bit vertical);
        wait_idle();
        repeat (4) @(negedge aclk);
        cfg_wr_data = vertical;
        cfg_wr_en   = 1'b1;
        shadow.mirror_vertical = vertical;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_port_address(bit [13:0] a);
        send_beat(OP_WRITE, REG_ADDR, {2'($urandom), a[13:8]});
        send_beat(OP_WRITE, REG_ADDR, a[7:0]);
    endtask

    task automatic tick_run(int n);
        repeat (n) send_beat(OP_TICK, reg_idx_t'($urandom), rand_byte());
    endtask

    // Fill a run of video memory, then read it back, often through a mirror.
    task automatic vram_transfer();
        bit [13:0] base;
        bit [13:0] back;
        int        n;
        send_beat(OP_READ, REG_STATUS, rand_byte());
        if ($urandom_range(0, 2) == 0) send_beat(OP_WRITE, REG_CTRL, rand_byte());
        case ($urandom_range(0, 3))
            0: base = 14'($urandom_range(0, 16'h1fff));
            1: base = 14'(16'h2000 + $urandom_range(0, 16'h0fff));
            2: base = 14'(16'h3000 + $urandom_range(0, 16'h0eff));
            default: base = 14'(16'h3f00 + $urandom_range(0, 16'h00ff));
        endcase
        n = $urandom_range(1, 8);
        set_port_address(base);
        repeat (n) send_beat(OP_WRITE, REG_DATA, rand_byte());
        // flip table-select bits to go through the other mirrors
        case ($urandom_range(0, 3))
            0: back = base;
            1: back = base ^ 14'h0400;
            2: back = base ^ 14'h0800;
            default: back = base ^ 14'h1000;
        endcase
        set_port_address(back);
        repeat (n + 1) send_beat(OP_READ, REG_DATA, rand_byte());
    endtask

    task automatic sprite_transfer();
        byte_t base;
        int    n;
        base = rand_byte();
        n = $urandom_range(1, 6);
        send_beat(OP_WRITE, REG_OAM_ADDR, base);
        repeat (n) send_beat(OP_WRITE, REG_OAM_DATA, rand_byte());
        send_beat(OP_WRITE, REG_OAM_ADDR, byte_t'(base + $urandom_range(0, n - 1)));
        repeat ($urandom_range(1, 3)) send_beat(OP_READ, REG_OAM_DATA, rand_byte());
    endtask

    task automatic random_traffic(int n);
        int goal;
        int pick;
        goal = items_sent + n;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                vram_transfer();
            end else if (pick < 45) begin
                sprite_transfer();
            end else if (pick < 55) begin
                send_beat(OP_READ, REG_STATUS, rand_byte());
                send_beat(OP_WRITE, REG_SCROLL, rand_byte());
                send_beat(OP_WRITE, REG_SCROLL, rand_byte());
            end else if (pick < 65) begin
                tick_run($urandom_range(1, 40));
            end else begin
                send_beat(opcode_t'($urandom_range(0, 3)), reg_idx_t'($urandom), rand_byte());
            end
        end
    endtask

    task automatic directed_checks();
        send_beat(OP_READ, REG_STATUS, 8'h00);
        // write-only register read returns the open bus untouched
        send_beat(OP_READ, REG_CTRL, 8'hff);
        send_beat(OP_WRITE, REG_STATUS, 8'hff);
        send_beat(OP_READ, REG_MASK, 8'h00);
        send_beat(OP_READ, REG_STATUS, 8'h00);
        send_beat(OP_UNUSED, REG_DATA, 8'hff);
        send_beat(OP_WRITE, REG_CTRL, CTRL_INC_32);
        set_port_address(14'h0000);
        send_beat(OP_WRITE, REG_DATA, 8'h00);
        send_beat(OP_WRITE, REG_DATA, 8'hff);
        set_port_address(14'h0000);
        send_beat(OP_READ, REG_DATA, 8'h00);
        send_beat(OP_READ, REG_DATA, 8'h00);
        // top address bits set on the high write are masked off
        send_beat(OP_WRITE, REG_ADDR, 8'hff);
        send_beat(OP_WRITE, REG_ADDR, 8'h1f);
        send_beat(OP_WRITE, REG_DATA, 8'hff);
        send_beat(OP_READ, REG_DATA, 8'h00);
        send_beat(OP_WRITE, REG_OAM_ADDR, 8'hff);
        send_beat(OP_WRITE, REG_OAM_DATA, 8'h80);
        send_beat(OP_WRITE, REG_OAM_ADDR, 8'hff);
        send_beat(OP_READ, REG_OAM_DATA, 8'h00);
        set_port_address(14'h3eff);
        send_beat(OP_WRITE, REG_DATA, 8'h3c);
        send_beat(OP_READ, REG_STATUS, 8'h00);
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        s_valid      = 1'b0;
        s_opcode     = OP_READ;
        s_reg_index  = REG_CTRL;
        s_write_data = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_mirroring(1'b0);
        directed_checks();
        random_traffic(250);
        set_mirroring(1'b1);
        random_traffic(300);
        set_mirroring(1'b0);
        random_traffic(270);

        wait_idle();
        repeat (8) @(negedge aclk);

        $display("run covered %0d input beats, %0d checked results, both mirroring modes",
                 shadow.beats_noted, shadow.results_checked);
        $display("results in vblank: %0d, with nmi raised: %0d, mismatches: %0d",
                 shadow.vblank_results, shadow.nmi_results, shadow.failures);
        if (shadow.failures == 0 && shadow.pending.size() == 0) begin
            $display("video_unit_register_port_top regression: pass");
        end else begin
            $display("video_unit_register_port_top regression: fail");
        end
        $finish;
    end

endmodule
